// File: hw/rtl/scit_pkg.sv
// ----------------------------------------------------------------------------
// Cut interval table package
// Shared types, request kinds and sizing constants.
// ----------------------------------------------------------------------------
package scit_pkg;

  localparam int MaxIntervalsDefault = 64;
  localparam int TimeW = 32;

  typedef enum logic [2:0] {
    KIND_CLEAR   = 3'd0,
    KIND_ADD     = 3'd1,
    KIND_LOOKUP  = 3'd2,
    KIND_REMOVE  = 3'd3,
    KIND_RESTORE = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_REQ,
    ST_SCAN_WAIT,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT_REQ,
    ST_SHIFT_WAIT,
    ST_SHIFT_WR,
    ST_INSERT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [TimeW-1:0] start;
    logic [TimeW-1:0] stop;
    logic             action;
  } entry_t;

endpackage

// File: hw/rtl/scit_mem.sv
// ----------------------------------------------------------------------------
// Cut interval table storage
// One write port and one registered read port over the interval entries.
// ----------------------------------------------------------------------------
module scit_mem #(
  parameter int Depth = scit_pkg::MaxIntervalsDefault,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  scit_pkg::entry_t wr_data,
  input  logic [AW-1:0]    rd_addr,
  output scit_pkg::entry_t rd_data
);

  scit_pkg::entry_t mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hw/rtl/sorted_cut_interval_table.sv
// ----------------------------------------------------------------------------
// Sorted cut interval table
// Sequencer that serves clear, add, lookup and time mapping requests.
// ----------------------------------------------------------------------------
// One request is taken at a time; stall stays high until its result transfer
// completes. Lookup, remove and restore read the table through the single
// read port of the entry memory, each entry in turn (address, then compare),
// over the N stored entries. An add scans all N entries, then shifts the
// entries above the insert point up by one, each with a read and then a
// write. No clearing pass is needed.
module sorted_cut_interval_table #(
  parameter int MAX_INTERVALS = scit_pkg::MaxIntervalsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [31:0] cut_start,
  input  logic [31:0] cut_end,
  input  logic        cut_action,
  input  logic [31:0] query_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        accepted,
  output logic        hit,
  output logic        hit_action,
  output logic [31:0] mapped_time,
  output logic [31:0] total_cut_time,
  output logic        have_cuts
);

  localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam logic [CW-1:0] FullCount = CW'(MAX_INTERVALS);

  scit_pkg::state_t state, state_next;

  logic [2:0]  req_kind;
  logic [31:0] req_s, req_e, req_q;
  logic        req_a;
  logic [CW-1:0] count;
  logic [31:0] sum;
  logic        flag;
  logic [CW-1:0] idx;       // scan index
  logic [CW-1:0] pos;       // insert position
  logic        pos_found;
  logic        reject;
  logic        done_scan;   // lookup finished early
  logic [32:0] acc;         // running time for remove/restore
  logic        r_hit, r_act, r_acc;

  logic             wr_en;
  logic [AW-1:0]    wr_addr, rd_addr;
  scit_pkg::entry_t wr_data, rd_data;

  scit_mem #(.Depth(MAX_INTERVALS)) u_mem (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  assign in_stall = (state != scit_pkg::ST_IDLE);
  assign out_valid = (state == scit_pkg::ST_DONE);

  // Shared compare unit per scan step on the entry just read.
  logic [31:0] len;
  logic s_in, e_in, contains, past_s, holds_q, past_q;
  assign len = rd_data.stop - rd_data.start;
  assign s_in = (rd_data.start <= req_s) && (rd_data.stop >= req_s);
  assign e_in = (rd_data.start <= req_e) && (rd_data.stop >= req_e);
  assign contains = (req_s < rd_data.start) && (req_e > rd_data.stop);
  assign past_s = rd_data.start > req_s;
  assign holds_q = (rd_data.start <= req_q) && (rd_data.stop >= req_q);
  assign past_q = rd_data.start > req_q;

  logic [33:0] sum_add;
  assign sum_add = {2'b0, sum} + {2'b0, req_e - req_s};

  always_comb begin
    state_next = state;
    wr_en = 1'b0;
    wr_addr = idx[AW-1:0];
    wr_data = rd_data;
    rd_addr = idx[AW-1:0];
    case (state)
      scit_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (kind == scit_pkg::KIND_LOOKUP || kind == scit_pkg::KIND_REMOVE ||
              kind == scit_pkg::KIND_RESTORE || kind == scit_pkg::KIND_ADD) begin
            state_next = scit_pkg::ST_SCAN_REQ;
          end else begin
            state_next = scit_pkg::ST_DONE;
          end
        end
      end
      scit_pkg::ST_SCAN_REQ: begin
        if (idx >= count || done_scan) begin
          state_next = (req_kind == scit_pkg::KIND_ADD) ? scit_pkg::ST_DECIDE
                                                         : scit_pkg::ST_DONE;
        end else begin
          state_next = scit_pkg::ST_SCAN;
        end
      end
      scit_pkg::ST_SCAN: state_next = scit_pkg::ST_SCAN_REQ;
      scit_pkg::ST_DECIDE: begin
        if (reject || count >= FullCount) begin
          state_next = scit_pkg::ST_DONE;
        end else if (idx > pos) begin
          state_next = scit_pkg::ST_SHIFT_REQ;
        end else begin
          state_next = scit_pkg::ST_INSERT;
        end
      end
      scit_pkg::ST_SHIFT_REQ: begin
        rd_addr = AW'(idx - CW'(1));
        state_next = scit_pkg::ST_SHIFT_WR;
      end
      scit_pkg::ST_SHIFT_WR: begin
        wr_en = 1'b1;
        wr_addr = idx[AW-1:0];
        wr_data = rd_data;
        state_next = (idx - CW'(1) > pos) ? scit_pkg::ST_SHIFT_REQ : scit_pkg::ST_INSERT;
      end
      scit_pkg::ST_INSERT: begin
        wr_en = 1'b1;
        wr_addr = pos[AW-1:0];
        wr_data.start = req_s;
        wr_data.stop = req_e;
        wr_data.action = req_a;
        state_next = scit_pkg::ST_DONE;
      end
      scit_pkg::ST_DONE: begin
        if (!out_stall) state_next = scit_pkg::ST_IDLE;
      end
      default: state_next = scit_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scit_pkg::ST_IDLE;
      count <= '0;
      sum <= '0;
      flag <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        scit_pkg::ST_IDLE: begin
          if (in_valid) begin
            req_kind <= kind;
            req_s <= cut_start;
            req_e <= cut_end;
            req_a <= cut_action;
            req_q <= query_time;
            idx <= '0;
            pos <= count;
            pos_found <= 1'b0;
            reject <= (cut_start >= cut_end);
            done_scan <= 1'b0;
            acc <= {1'b0, query_time};
            r_hit <= 1'b0;
            r_act <= 1'b0;
            r_acc <= 1'b0;
            if (kind == scit_pkg::KIND_CLEAR) begin
              count <= '0;
              sum <= '0;
              flag <= 1'b0;
            end
            if (kind == scit_pkg::KIND_ADD) flag <= 1'b0;
          end
        end
        scit_pkg::ST_SCAN: begin
          idx <= idx + CW'(1);
          case (req_kind)
            scit_pkg::KIND_ADD: begin
              if (s_in || e_in || contains) reject <= 1'b1;
              if (past_s && !pos_found) begin
                pos <= idx;
                pos_found <= 1'b1;
              end
            end
            scit_pkg::KIND_LOOKUP: begin
              if (holds_q) begin
                r_hit <= 1'b1;
                r_act <= rd_data.action;
                done_scan <= 1'b1;
              end else if (past_q) begin
                done_scan <= 1'b1;
              end
            end
            scit_pkg::KIND_REMOVE: begin
              if (!rd_data.action && rd_data.stop <= req_q) acc <= acc - {1'b0, len};
            end
            scit_pkg::KIND_RESTORE: begin
              if (!rd_data.action && {1'b0, rd_data.start} <= acc && !r_acc) begin
                if ({1'b0, acc} + {2'b0, len} > 34'h0FFFFFFFF) begin
                  r_acc <= 1'b1;
                  acc <= 33'h0FFFFFFFF;
                end else begin
                  acc <= acc + {1'b0, len};
                end
              end
            end
            default: ;
          endcase
        end
        scit_pkg::ST_DECIDE: begin
          if (!(reject || count >= FullCount)) begin
            idx <= count;
            r_acc <= 1'b0;
          end
        end
        scit_pkg::ST_SHIFT_WR: idx <= idx - CW'(1);
        scit_pkg::ST_INSERT: begin
          count <= count + CW'(1);
          flag <= 1'b1;
          r_acc <= 1'b1;
          if (!req_a) sum <= (sum_add[33:32] != 2'b0) ? 32'hFFFFFFFF : sum_add[31:0];
        end
        default: ;
      endcase
    end
  end

  // Saturated restore keeps scanning but stops adding; acc stays at max.
  logic map_kind;
  assign map_kind = (req_kind == scit_pkg::KIND_REMOVE) || (req_kind == scit_pkg::KIND_RESTORE);
  assign accepted = (req_kind == scit_pkg::KIND_ADD) && r_acc;
  assign hit = (req_kind == scit_pkg::KIND_LOOKUP) && r_hit;
  assign hit_action = (req_kind == scit_pkg::KIND_LOOKUP) && r_hit && r_act;
  assign mapped_time = !map_kind ? 32'd0 : (!flag ? req_q : acc[31:0]);
  assign total_cut_time = flag ? sum : 32'd0;
  assign have_cuts = flag;

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != scit_pkg::ST_IDLE) |-> in_stall)
    else $error("stall low while busy");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FullCount)
    else $error("entry count exceeds table depth");
  a_flag_on_add: assert property (@(posedge clk) disable iff (rst)
    $rose(flag) |-> $past(state) == scit_pkg::ST_INSERT)
    else $error("have-cuts flag set outside an insert");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cut interval table testbench
// Drives clear, add, lookup, time mapping and unused-kind requests through the
// valid/stall channels, with random idle bursts on both sides, and checks
// every result transfer against a behavioral predictor of the table or, for
// some directed requests, against a fixed expected result.
module tb_top;

  localparam int Depth = scit_pkg::MaxIntervalsDefault;
  localparam int NumRandom = 800;
  localparam int CycleLimit = 2000000;
  localparam logic [2:0] KindSpareLo = 3'd5;
  localparam logic [2:0] KindSpareHi = 3'd7;
  localparam logic [31:0] TimeMax = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        accepted;
    logic        hit;
    logic        hit_action;
    logic [31:0] mapped_time;
    logic [31:0] total_cut_time;
    logic        have_cuts;
  } result_t;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] cut_start;
    logic [31:0] cut_end;
    logic        cut_action;
    logic [31:0] query_time;
    bit          typed;
    result_t     exp;
  } request_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  kind = scit_pkg::KIND_CLEAR;
  logic [31:0] cut_start = '0;
  logic [31:0] cut_end = '0;
  logic        cut_action = 1'b0;
  logic [31:0] query_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        accepted;
  logic        hit;
  logic        hit_action;
  logic [31:0] mapped_time;
  logic [31:0] total_cut_time;
  logic        have_cuts;

  // Predictor copy of the interval table.
  logic [31:0] tbl_start [Depth];
  logic [31:0] tbl_stop [Depth];
  logic        tbl_action [Depth];
  int          tbl_count = 0;
  logic [31:0] cut_sum = '0;
  logic        cuts_flag = 1'b0;

  result_t     pending_results [$];
  request_t    directed [$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          quiet = 1'b0;

  sorted_cut_interval_table i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .cut_start(cut_start), .cut_end(cut_end),
    .cut_action(cut_action), .query_time(query_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .accepted(accepted), .hit(hit), .hit_action(hit_action),
    .mapped_time(mapped_time), .total_cut_time(total_cut_time),
    .have_cuts(have_cuts)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic bit holder_of(input logic [31:0] t, output int idx);
    idx = 0;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_start[i] <= t && tbl_stop[i] >= t) begin
        idx = i;
        return 1'b1;
      end
      if (tbl_start[i] > t) return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic bit insert_interval(input logic [31:0] s, input logic [31:0] e,
                                         input logic act);
    int idx;
    int pos;
    bit [32:0] sum;
    cuts_flag = 1'b0;
    if (s >= e) return 1'b0;
    if (holder_of(s, idx) || holder_of(e, idx)) return 1'b0;
    for (int i = 0; i < tbl_count; i++)
      if (s < tbl_start[i] && e > tbl_stop[i]) return 1'b0;
    if (tbl_count >= Depth) return 1'b0;
    pos = tbl_count;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_start[i] > s) begin
        pos = i;
        break;
      end
    end
    for (int i = tbl_count; i > pos; i--) begin
      tbl_start[i] = tbl_start[i-1];
      tbl_stop[i] = tbl_stop[i-1];
      tbl_action[i] = tbl_action[i-1];
    end
    tbl_start[pos] = s;
    tbl_stop[pos] = e;
    tbl_action[pos] = act;
    tbl_count++;
    if (act == 1'b0) begin
      sum = {1'b0, cut_sum} + {1'b0, e - s};
      cut_sum = sum[32] ? TimeMax : sum[31:0];
    end
    cuts_flag = 1'b1;
    return 1'b1;
  endfunction

  function automatic result_t predict_table(input request_t r);
    result_t res;
    int idx;
    bit [63:0] acc;
    res = '0;
    case (r.kind)
      scit_pkg::KIND_CLEAR: begin
        tbl_count = 0;
        cut_sum = '0;
        cuts_flag = 1'b0;
      end
      scit_pkg::KIND_ADD: begin
        res.accepted = insert_interval(r.cut_start, r.cut_end, r.cut_action);
      end
      scit_pkg::KIND_LOOKUP: begin
        if (holder_of(r.query_time, idx)) begin
          res.hit = 1'b1;
          res.hit_action = tbl_action[idx];
        end
      end
      scit_pkg::KIND_REMOVE: begin
        if (!cuts_flag) begin
          res.mapped_time = r.query_time;
        end else begin
          acc = '0;
          for (int i = 0; i < tbl_count; i++)
            if (!tbl_action[i] && tbl_stop[i] <= r.query_time)
              acc += tbl_stop[i] - tbl_start[i];
          res.mapped_time = (acc >= r.query_time) ? '0 : r.query_time - acc[31:0];
        end
      end
      scit_pkg::KIND_RESTORE: begin
        if (!cuts_flag) begin
          res.mapped_time = r.query_time;
        end else begin
          acc = r.query_time;
          for (int i = 0; i < tbl_count; i++)
            if (!tbl_action[i] && tbl_start[i] <= acc)
              acc += tbl_stop[i] - tbl_start[i];
          res.mapped_time = (acc > TimeMax) ? TimeMax : acc[31:0];
        end
      end
      default: ;
    endcase
    res.total_cut_time = cuts_flag ? cut_sum : '0;
    res.have_cuts = cuts_flag;
    return res;
  endfunction

  // Called at a rising edge; returns at the edge where the transfer happens.
  task automatic send_request(input request_t r);
    result_t res;
    kind <= r.kind;
    cut_start <= r.cut_start;
    cut_end <= r.cut_end;
    cut_action <= r.cut_action;
    query_time <= r.query_time;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    res = predict_table(r);
    if (r.typed) res = r.exp;
    pending_results = {pending_results, res};
  endtask

  task automatic idle_gap();
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void row(input logic [2:0] k, input logic [31:0] s, input logic [31:0] e,
                              input logic a, input logic [31:0] q, input bit typed,
                              input result_t exp);
    request_t r;
    r = '{k, s, e, a, q, typed, exp};
    directed = {directed, r};
  endfunction

  function automatic result_t rs(input logic a, input logic h, input logic ha,
                                 input logic [31:0] m, input logic [31:0] t, input logic c);
    return '{a, h, ha, m, t, c};
  endfunction

  // Receiver side: random stall bursts, none once the run goes quiet.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no request outstanding");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, accepted);
          error_count++;
        end
        if (hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit);
          error_count++;
        end
        if (hit_action !== want.hit_action) begin
          $error("hit_action: expected %0d, got %0d", want.hit_action, hit_action);
          error_count++;
        end
        if (mapped_time !== want.mapped_time) begin
          $error("mapped_time: expected %0d, got %0d", want.mapped_time, mapped_time);
          error_count++;
        end
        if (total_cut_time !== want.total_cut_time) begin
          $error("total_cut_time: expected %0d, got %0d", want.total_cut_time,
                 total_cut_time);
          error_count++;
        end
        if (have_cuts !== want.have_cuts) begin
          $error("have_cuts: expected %0d, got %0d", want.have_cuts, have_cuts);
          error_count++;
        end
      end
    end
  end

  initial begin
    request_t    r;
    int          sent;
    int          phase_len;
    logic [31:0] win;
    logic [31:0] off;
    logic [31:0] len;
    int          pick;

    // Directed requests: empty table, rejections, endpoints, saturation and unused kinds.
    row(scit_pkg::KIND_LOOKUP, 0, 0, 0, 0, 1, rs(0, 0, 0, 0, 0, 0));
    row(scit_pkg::KIND_REMOVE, 0, 0, 0, TimeMax, 1, rs(0, 0, 0, TimeMax, 0, 0));
    row(scit_pkg::KIND_ADD, 5, 5, 0, 0, 1, rs(0, 0, 0, 0, 0, 0));
    row(scit_pkg::KIND_ADD, 10, 20, 0, 0, 1, rs(1, 0, 0, 0, 10, 1));
    row(scit_pkg::KIND_ADD, 15, 30, 0, 0, 1, rs(0, 0, 0, 0, 0, 0));
    row(scit_pkg::KIND_REMOVE, 0, 0, 0, 100, 1, rs(0, 0, 0, 100, 0, 0));
    row(scit_pkg::KIND_ADD, 5, 25, 1, 0, 0, '0);
    row(scit_pkg::KIND_ADD, 0, 9, 1, 0, 0, '0);
    row(scit_pkg::KIND_ADD, 20, 40, 0, 0, 0, '0);
    row(scit_pkg::KIND_ADD, 32'hFFFF_FFF0, TimeMax, 0, 0, 0, '0);
    row(scit_pkg::KIND_LOOKUP, 0, 0, 0, 10, 0, '0);
    row(scit_pkg::KIND_LOOKUP, 0, 0, 0, 9, 0, '0);
    row(scit_pkg::KIND_LOOKUP, 0, 0, 0, 21, 0, '0);
    row(scit_pkg::KIND_LOOKUP, 0, 0, 0, TimeMax, 0, '0);
    row(scit_pkg::KIND_REMOVE, 0, 0, 0, 20, 0, '0);
    row(scit_pkg::KIND_REMOVE, 0, 0, 0, 19, 0, '0);
    row(scit_pkg::KIND_RESTORE, 0, 0, 0, 10, 0, '0);
    row(scit_pkg::KIND_RESTORE, 0, 0, 0, 32'hFFFF_FFF0, 0, '0);
    row(KindSpareLo, TimeMax, TimeMax, 1, TimeMax, 0, '0);
    row(KindSpareHi, 0, 0, 0, 0, 0, '0);
    row(scit_pkg::KIND_CLEAR, 0, 0, 0, 0, 1, rs(0, 0, 0, 0, 0, 0));
    row(scit_pkg::KIND_RESTORE, 0, 0, 0, 77, 1, rs(0, 0, 0, 77, 0, 0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) begin
      send_request(directed[i]);
      idle_gap();
    end
    drain_results();

    sent = 0;
    while (sent < NumRandom) begin
      if (sent >= NumRandom - 100) quiet = 1'b1;
      case ($urandom_range(0, 3))
        0: win = 32'd64;
        1: win = 32'd4096;
        2: win = 32'd1 << 20;
        default: win = TimeMax;
      endcase
      off = (win == TimeMax) ? '0 : $urandom_range(0, TimeMax - win);
      if ($urandom_range(0, 2) == 0) begin
        r = '{scit_pkg::KIND_CLEAR, $urandom, $urandom, $urandom_range(0, 1), $urandom,
              0, '0};
        send_request(r);
        sent++;
      end
      if ($urandom_range(0, 9) == 0) begin
        // Fill the table in order, running past full.
        for (int i = 0; i < Depth + 2; i++) begin
          r.kind = scit_pkg::KIND_ADD;
          r.typed = 1'b0;
          r.cut_start = off + i * 100;
          r.cut_end = r.cut_start + $urandom_range(1, 50);
          r.cut_action = $urandom_range(0, 1);
          r.query_time = $urandom;
          send_request(r);
          sent++;
          idle_gap();
        end
      end
      phase_len = $urandom_range(40, 120);
      for (int n = 0; n < phase_len; n++) begin
        r.cut_action = $urandom_range(0, 1);
        r.query_time = $urandom;
        r.typed = 1'b0;
        r.cut_start = off + $urandom_range(0, win);
        len = $urandom_range(1, (win >> 6) + 1);
        r.cut_end = (r.cut_start > TimeMax - len) ? TimeMax : r.cut_start + len;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          r.kind = scit_pkg::KIND_ADD;
          if ($urandom_range(0, 9) == 0) begin
            r.cut_start = $urandom;
            r.cut_end = $urandom;
          end
        end else if (pick < 65) begin
          r.kind = scit_pkg::KIND_LOOKUP;
        end else if (pick < 80) begin
          r.kind = scit_pkg::KIND_REMOVE;
        end else if (pick < 95) begin
          r.kind = scit_pkg::KIND_RESTORE;
        end else if (pick < 97) begin
          r.kind = scit_pkg::KIND_CLEAR;
        end else begin
          r.kind = $urandom_range(KindSpareLo, KindSpareHi);
        end
        // Aim about half of the non-add queries at or near stored endpoints.
        if (r.kind != scit_pkg::KIND_ADD && tbl_count > 0 && $urandom_range(0, 1) == 0) begin
          idx_pick: begin
            int k;
            k = $urandom_range(0, tbl_count - 1);
            r.query_time = ($urandom_range(0, 1) ? tbl_start[k] : tbl_stop[k]) +
                           $urandom_range(0, 2) - 1;
          end
        end
        send_request(r);
        sent++;
        idle_gap();
      end
      if ($urandom_range(0, 3) == 0) drain_results();
    end

    drain_results();
    repeat (300) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
